### src/crc32rc_pkg.sv
`timescale 1ns / 1ps

package crc32rc_pkg;

   localparam int unsigned CRC_W  = 32;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W  = 11;
   localparam int unsigned CSR_IDX_W = 2;

   typedef logic [CRC_W-1:0]     crc_type;
   typedef logic [BYTE_W-1:0]    byte_type;
   typedef logic [LEN_W-1:0]     len_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   // Register indexes on the configuration port.
   localparam csr_index_type CSR_POLYNOMIAL = 2'd0;
   localparam csr_index_type CSR_INITIAL    = 2'd1;
   localparam csr_index_type CSR_LENGTH     = 2'd2;

   localparam crc_type CRC_ALL_ONES   = 32'hFFFF_FFFF;
   localparam crc_type POLY_RESET     = 32'hEDB8_8320;
   localparam crc_type INITIAL_RESET  = 32'hFFFF_FFFF;
   localparam len_type LENGTH_RESET   = 11'd64;

   typedef enum logic [1:0] {
      PH_RECORD   = 2'd0,
      PH_TRAIL_LO = 2'd1,
      PH_TRAIL_HI = 2'd2,
      PH_IDLE     = 2'd3
   } phase_type;

endpackage

### src/crc32rc_req_if.sv
`timescale 1ns / 1ps

interface crc32rc_req_if;
   logic                  valid;
   logic                  ready;
   crc32rc_pkg::byte_type data_byte;
   logic                  first;

   modport source (output valid, output data_byte, output first, input ready);
   modport sink   (input valid, input data_byte, input first, output ready);
endinterface

### src/crc32rc_rsp_if.sv
`timescale 1ns / 1ps

interface crc32rc_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 match;
   crc32rc_pkg::crc_type crc_value;

   modport source (output valid, output match, output crc_value, input ready);
   modport sink   (input valid, input match, input crc_value, output ready);
endinterface

### src/crc32rc_csr_if.sv
`timescale 1ns / 1ps

interface crc32rc_csr_if;
   logic                       valid;
   logic                       ready;
   crc32rc_pkg::csr_index_type index;
   crc32rc_pkg::crc_type       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### src/crc32_record_checker_unit.sv
`timescale 1ns / 1ps

// CRC-32 record checker.
// The req channel carries one byte per word: a record of record_length bytes
// (the first flagged with first = 1), then two trailer bytes, low byte first.
// Each record byte runs through a reflected CRC-32 update with the configured
// polynomial, starting from crc_initial. On the second trailer byte one word
// leaves on the rsp channel: crc_value is the CRC XOR all ones, and match says
// whether the trailer equals its low 16 bits. Other bytes give no result.
// The csr channel writes polynomial, initial value and record length; it is
// always ready. It is to be used only while no byte is in flight; the user
// must keep to this, as the block does not enforce it. A trailer byte goes
// from req acceptance into the input register, then through the byte update
// and trailer compare into the result register. Throughput is one byte per
// cycle while rsp is not stalled; the running CRC update is combinational.
// When rsp is stalled the result register holds, the input register still
// takes one more byte, and req_ch.ready then drops until the result is taken.
// Reset (synchronous) loads the default configuration and leaves the block
// idle: bytes without first are dropped until a first byte arrives.
module crc32_record_checker_unit #(
   parameter int unsigned MAX_RECORD_BYTES = 1024
) (
   input logic           clock,
   input logic           reset,
   crc32rc_req_if.sink   req_ch,
   crc32rc_rsp_if.source rsp_ch,
   crc32rc_csr_if.sink   csr_ch
);
   import crc32rc_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_RECORD_BYTES + 1);
   localparam int unsigned CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_RECORD_BYTES);

   // Configuration.
   crc_type poly_ff;
   crc_type init_ff;
   len_type len_ff;

   // Input register.
   logic     stage_valid_ff;
   byte_type stage_data_ff;
   logic     stage_first_ff;

   // Record state.
   phase_type        state_ff,       state_in;
   crc_type          crc_ff,         crc_in;
   logic [CNT_W-1:0] count_ff,       count_in;
   byte_type         trailer_low_ff, trailer_low_in;

   // Result register.
   logic    rsp_valid_ff;
   logic    rsp_match_ff, rsp_match_in;
   crc_type rsp_crc_ff,   rsp_crc_in;

   logic             advance;
   logic             process;
   logic             load_rsp;
   phase_type        phase_eff;
   crc_type          crc_base;
   crc_type          crc_updated;
   crc_type          crc_final;
   logic [CNT_W-1:0] count_base;
   logic [CMP_W-1:0] len_ext;
   logic [CMP_W-1:0] eff_len;

   assign advance = !rsp_valid_ff || rsp_ch.ready;
   assign process = stage_valid_ff && advance;

   assign req_ch.ready = !stage_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= POLY_RESET;
         init_ff <= INITIAL_RESET;
         len_ff  <= LENGTH_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_POLYNOMIAL: poly_ff <= csr_ch.data;
            CSR_INITIAL:    init_ff <= csr_ch.data;
            CSR_LENGTH:     len_ff  <= csr_ch.data[LEN_W-1:0];
            default:        ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ch.valid && req_ch.ready) begin
         stage_valid_ff <= 1'b1;
      end else if (advance) begin
         stage_valid_ff <= 1'b0;
      end
      if (req_ch.valid && req_ch.ready) begin
         stage_data_ff  <= req_ch.data_byte;
         stage_first_ff <= req_ch.first;
      end
   end

   // A zero length counts as one; lengths past the maximum saturate.
   always_comb begin
      len_ext = CMP_W'(len_ff);
      if (len_ff == '0) begin
         eff_len = CMP_W'(1);
      end else if (len_ext > MAX_LEN) begin
         eff_len = MAX_LEN;
      end else begin
         eff_len = len_ext;
      end
   end

   // A first byte restarts the record from whatever phase is current.
   assign phase_eff  = stage_first_ff ? PH_RECORD : state_ff;
   assign crc_base   = stage_first_ff ? init_ff : crc_ff;
   assign count_base = stage_first_ff ? '0 : count_ff;
   assign crc_final  = crc_base ^ CRC_ALL_ONES;

   crc32rc_byte_update u_update (
      .crc_in     (crc_base),
      .polynomial (poly_ff),
      .data_byte  (stage_data_ff),
      .crc_out    (crc_updated)
   );

   always_comb begin
      state_in       = state_ff;
      crc_in         = crc_ff;
      count_in       = count_ff;
      trailer_low_in = trailer_low_ff;
      load_rsp       = 1'b0;
      rsp_match_in   = ({stage_data_ff, trailer_low_ff} == crc_final[15:0]);
      rsp_crc_in     = crc_final;
      if (process) begin
         unique case (phase_eff)
            PH_RECORD: begin
               crc_in         = crc_updated;
               count_in       = count_base + 1'b1;
               trailer_low_in = '0;
               if (CMP_W'(count_in) >= eff_len) begin
                  state_in = PH_TRAIL_LO;
               end else begin
                  state_in = PH_RECORD;
               end
            end
            PH_TRAIL_LO: begin
               trailer_low_in = stage_data_ff;
               state_in       = PH_TRAIL_HI;
            end
            PH_TRAIL_HI: begin
               load_rsp = 1'b1;
               state_in = PH_IDLE;
            end
            PH_IDLE: begin
               state_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= PH_IDLE;
         crc_ff         <= '0;
         count_ff       <= '0;
         trailer_low_ff <= '0;
      end else begin
         state_ff       <= state_in;
         crc_ff         <= crc_in;
         count_ff       <= count_in;
         trailer_low_ff <= trailer_low_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_rsp) begin
         rsp_match_ff <= rsp_match_in;
         rsp_crc_ff   <= rsp_crc_in;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.match     = rsp_match_ff;
   assign rsp_ch.crc_value = rsp_crc_ff;

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (state_ff == PH_IDLE && !rsp_valid_ff && !stage_valid_ff))
      else $error("block not idle after reset");

   a_result_ends_record: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (state_ff == PH_IDLE))
      else $error("result issued without closing the record");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !advance) |=>
         (stage_valid_ff && $stable(stage_data_ff) && $stable(stage_first_ff)))
      else $error("input register lost a byte during a stall");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= MAX_LEN)
      else $error("byte count beyond the maximum record length");

endmodule

### src/crc32rc_byte_update.sv
`timescale 1ns / 1ps

module crc32rc_byte_update (
   input  crc32rc_pkg::crc_type  crc_in,
   input  crc32rc_pkg::crc_type  polynomial,
   input  crc32rc_pkg::byte_type data_byte,
   output crc32rc_pkg::crc_type  crc_out
);
   import crc32rc_pkg::*;

   crc_type step_r;

   // Reflected CRC: one polynomial step per data bit, LSB first.
   always_comb begin
      step_r = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_byte};
      for (int k = 0; k < BYTE_W; k++) begin
         if (step_r[0]) begin
            step_r = (step_r >> 1) ^ polynomial;
         end else begin
            step_r = step_r >> 1;
         end
      end
   end

   assign crc_out = step_r;

endmodule
